// ===== src/shp_pkg.sv =====
// Shared types and constants for the salted handle slot pool.
// No dependencies; used by shp_salt_ram and salted_handle_slot_pool_unit.
package shp_pkg;

  localparam int SALT_W     = 16;
  localparam int HANDLE_W   = 32;
  localparam int SLOT_IN_W  = 16;
  localparam int SLOT_OUT_W = 8;
  localparam int MODE_W     = 4;
  localparam int STATUS_W   = 4;
  localparam int LIMIT_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // request modes
  localparam logic [MODE_W-1:0] MD_ALLOC            = 4'd0;
  localparam logic [MODE_W-1:0] MD_ALLOC_AT         = 4'd1;
  localparam logic [MODE_W-1:0] MD_FREE             = 4'd2;
  localparam logic [MODE_W-1:0] MD_LOOKUP           = 4'd3;
  localparam logic [MODE_W-1:0] MD_LOOKUP_SLOT      = 4'd4;
  localparam logic [MODE_W-1:0] MD_LOOKUP_UNCHECKED = 4'd5;
  localparam logic [MODE_W-1:0] MD_CLEAR_ALL        = 4'd6;
  localparam logic [MODE_W-1:0] MD_ITER_RESTART     = 4'd7;
  localparam logic [MODE_W-1:0] MD_ITER_NEXT        = 4'd8;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 4'd0;
  localparam logic [STATUS_W-1:0] ST_NULL     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_FREE     = 4'd3;
  localparam logic [STATUS_W-1:0] ST_STALE    = 4'd4;
  localparam logic [STATUS_W-1:0] ST_FULL     = 4'd5;
  localparam logic [STATUS_W-1:0] ST_OCCUPIED = 4'd6;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 4'd7;
  localparam logic [STATUS_W-1:0] ST_END      = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SALT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_ENABLED = 2'd2;

  localparam logic [HANDLE_W-1:0] NULL_HANDLE    = 32'hFFFF_FFFF;
  localparam logic [SALT_W-1:0]   SALT_TOP       = 16'h8000;
  localparam logic [SALT_W-1:0]   SALT_MAX       = 16'hFFFF;
  localparam logic [SALT_W-1:0]   INIT_SALT_RST  = 16'd57699;
  localparam logic [LIMIT_W-1:0]  SLOT_LIMIT_RST = 9'd256;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [HANDLE_W-1:0]   handle;
    logic [SLOT_OUT_W-1:0] slot;
  } res_t;

endpackage

// ===== src/salted_handle_slot_pool_unit.sv =====
// Salted handle slot pool: top level, control sequencer and registers.
// Depends on shp_pkg and shp_salt_ram.
//
// Usage
//   Request channel: mode, handle_in, slot_in with in_valid / in_stall. One
//   request is worked on at a time; in_stall is high while a request is in
//   flight, while a finished result waits for the output register, and
//   during a table clearing sweep.
//   Result channel: status, handle_out, slot_out with out_valid / out_stall,
//   driven from an output register. One result per request.
//   Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
//   slot_limit (0), initial_salt (1) or pool_enabled (2); other indexes are
//   ignored. Write only while the pool is idle.
// Sequencing (from accept to result in output register)
//   Refusals found at accept, lookup_unchecked, iter_restart: no table read.
//   lookup, lookup_slot, free, alloc_at: one salt table read, then check
//   and, for free and alloc_at, write back.
//   alloc: probes slots from the free hint until one is free or the limit.
//   iter_next: walks slots until an occupied one or high_water.
//   clear_all: clears entries below high_water, one table entry per cycle.
// Reset: a sweep zeroes all CAPACITY salt table entries; requests stall
// until it ends. Config writes are taken during the sweep.
// Receiver stall: a result waits in the output register; the next request is
// still taken, and its result parks in a holding register until space opens.
module salted_handle_slot_pool_unit #(
  parameter int CAPACITY = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [shp_pkg::MODE_W-1:0]        mode,
  input  logic [shp_pkg::HANDLE_W-1:0]      handle_in,
  input  logic [shp_pkg::SLOT_IN_W-1:0]     slot_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [shp_pkg::STATUS_W-1:0]      status,
  output logic [shp_pkg::HANDLE_W-1:0]      handle_out,
  output logic [shp_pkg::SLOT_OUT_W-1:0]    slot_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [shp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [shp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // table address
  localparam int CW = $clog2(CAPACITY + 1);                    // counts to CAPACITY
  localparam logic [15:0]   CAP16 = 16'(CAPACITY);
  localparam logic [CW-1:0] CAPC  = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE   = CW'(1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_HOLD  = 2'd3;

  // registers
  logic [1:0]                       state, state_next;
  logic [shp_pkg::MODE_W-1:0]       op, op_next;
  logic [shp_pkg::HANDLE_W-1:0]     hreg, hreg_next;
  logic [CW-1:0]                    cursor, cursor_next;
  logic [CW-1:0]                    walk_cursor, walk_cursor_next;
  logic [CW-1:0]                    free_hint, free_hint_next;
  logic [CW-1:0]                    high_water, high_water_next;
  logic [shp_pkg::SALT_W-1:0]       next_salt, next_salt_next;
  logic [CW-1:0]                    clr_ptr, clr_ptr_next;
  logic                             clr_boot, clr_boot_next;
  logic                             out_valid_next;
  shp_pkg::res_t                    obuf, obuf_next;
  shp_pkg::res_t                    hold, hold_next;
  logic [shp_pkg::LIMIT_W-1:0]      slot_limit;
  logic [shp_pkg::SALT_W-1:0]       initial_salt;
  logic                             pool_enabled;

  // table port
  logic                             ram_we, ram_re;
  logic [IW-1:0]                    ram_waddr, ram_raddr;
  logic [shp_pkg::SALT_W-1:0]       ram_wdata, ram_rdata;

  // combinational helpers
  logic                             e_valid;
  shp_pkg::res_t                    e_res;
  logic [15:0]                      s16, hw16, lim16;
  logic [CW-1:0]                    limc, clr_bound, cur_inc, wc_inc;
  logic                             is_null, out_free;

  function automatic shp_pkg::res_t fail_res(input logic [shp_pkg::STATUS_W-1:0] st);
    fail_res = '{status: st, handle: shp_pkg::NULL_HANDLE, slot: '0};
  endfunction

  function automatic shp_pkg::res_t ok_res(input logic [shp_pkg::HANDLE_W-1:0] h,
                                           input logic [CW-1:0] sl);
    ok_res = '{status: shp_pkg::ST_OK, handle: h, slot: shp_pkg::SLOT_OUT_W'(sl)};
  endfunction

  function automatic logic [shp_pkg::SALT_W-1:0] advance_salt(
      input logic [shp_pkg::SALT_W-1:0] s);
    advance_salt = (s == shp_pkg::SALT_MAX) ? shp_pkg::SALT_TOP
                                            : ((s + 16'd1) | shp_pkg::SALT_TOP);
  endfunction

  shp_salt_ram #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall   = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign status     = obuf.status;
  assign handle_out = obuf.handle;
  assign slot_out   = obuf.slot;

  assign s16     = handle_in[15:0];
  assign is_null = (handle_in == shp_pkg::NULL_HANDLE);
  assign hw16    = 16'(high_water);
  // limit register clamps to the built capacity
  assign lim16   = ({7'd0, slot_limit} > CAP16) ? CAP16 : {7'd0, slot_limit};
  assign limc    = lim16[CW-1:0];
  assign clr_bound = clr_boot ? CAPC : high_water;
  assign cur_inc = cursor + ONE;
  assign wc_inc  = walk_cursor + ONE;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next       = state;
    op_next          = op;
    hreg_next        = hreg;
    cursor_next      = cursor;
    walk_cursor_next = walk_cursor;
    free_hint_next   = free_hint;
    high_water_next  = high_water;
    next_salt_next   = next_salt;
    clr_ptr_next     = clr_ptr;
    clr_boot_next    = clr_boot;
    out_valid_next   = out_valid && out_stall;
    obuf_next        = obuf;
    hold_next        = hold;
    ram_we           = 1'b0;
    ram_waddr        = cursor[IW-1:0];
    ram_wdata        = '0;
    ram_re           = 1'b0;
    ram_raddr        = cursor[IW-1:0];
    e_valid          = 1'b0;
    e_res            = fail_res(shp_pkg::ST_OK);

    unique case (state)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_ptr[IW-1:0];
        clr_ptr_next = clr_ptr + ONE;
        if ((clr_ptr + ONE) >= clr_bound) begin
          high_water_next = '0;
          clr_boot_next   = 1'b0;
          if (clr_boot) begin
            state_next = S_IDLE;
          end else begin
            e_valid = 1'b1;
            e_res   = fail_res(shp_pkg::ST_OK);
          end
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_next   = mode;
          hreg_next = handle_in;
          unique case (mode)
            shp_pkg::MD_ALLOC: begin
              if (!pool_enabled) begin
                e_valid = 1'b1;
                e_res   = fail_res(shp_pkg::ST_DISABLED);
              end else if (free_hint >= limc) begin
                e_valid = 1'b1;
                e_res   = fail_res(shp_pkg::ST_FULL);
              end else begin
                ram_re      = 1'b1;
                ram_raddr   = free_hint[IW-1:0];
                cursor_next = free_hint;
                state_next  = S_CHECK;
              end
            end
            shp_pkg::MD_ALLOC_AT: begin
              if (!pool_enabled) begin
                e_valid = 1'b1;
                e_res   = fail_res(shp_pkg::ST_DISABLED);
              end else if (is_null || handle_in[31:16] == '0) begin
                e_valid = 1'b1;
                e_res   = fail_res(shp_pkg::ST_NULL);
              end else if (s16 >= lim16) begin
                e_valid = 1'b1;
                e_res   = fail_res(shp_pkg::ST_RANGE);
              end else begin
                ram_re      = 1'b1;
                ram_raddr   = s16[IW-1:0];
                cursor_next = s16[CW-1:0];
                state_next  = S_CHECK;
              end
            end
            shp_pkg::MD_FREE, shp_pkg::MD_LOOKUP: begin
              if (is_null) begin
                e_valid = 1'b1;
                e_res   = fail_res(shp_pkg::ST_NULL);
              end else if (s16 >= hw16) begin
                e_valid = 1'b1;
                e_res   = fail_res(shp_pkg::ST_RANGE);
              end else begin
                ram_re      = 1'b1;
                ram_raddr   = s16[IW-1:0];
                cursor_next = s16[CW-1:0];
                state_next  = S_CHECK;
              end
            end
            shp_pkg::MD_LOOKUP_SLOT: begin
              if (slot_in >= hw16) begin
                e_valid = 1'b1;
                e_res   = fail_res(shp_pkg::ST_RANGE);
              end else begin
                ram_re      = 1'b1;
                ram_raddr   = slot_in[IW-1:0];
                cursor_next = slot_in[CW-1:0];
                state_next  = S_CHECK;
              end
            end
            shp_pkg::MD_LOOKUP_UNCHECKED: begin
              e_valid = 1'b1;
              if (is_null) begin
                e_res = fail_res(shp_pkg::ST_NULL);
              end else if (s16 >= lim16) begin
                e_res = fail_res(shp_pkg::ST_RANGE);
              end else begin
                e_res = '{status: shp_pkg::ST_OK, handle: handle_in,
                          slot: s16[shp_pkg::SLOT_OUT_W-1:0]};
              end
            end
            shp_pkg::MD_CLEAR_ALL: begin
              free_hint_next = '0;
              next_salt_next = initial_salt | shp_pkg::SALT_TOP;
              if (high_water == '0) begin
                e_valid = 1'b1;
                e_res   = fail_res(shp_pkg::ST_OK);
              end else begin
                // only slots below high_water can be live
                clr_ptr_next = '0;
                state_next   = S_CLEAR;
              end
            end
            shp_pkg::MD_ITER_RESTART: begin
              walk_cursor_next = '0;
              e_valid          = 1'b1;
              e_res            = fail_res(shp_pkg::ST_OK);
            end
            shp_pkg::MD_ITER_NEXT: begin
              if (walk_cursor >= high_water) begin
                e_valid = 1'b1;
                e_res   = fail_res(shp_pkg::ST_END);
              end else begin
                ram_re           = 1'b1;
                ram_raddr        = walk_cursor[IW-1:0];
                cursor_next      = walk_cursor;
                walk_cursor_next = wc_inc;
                state_next       = S_CHECK;
              end
            end
            default: begin
              e_valid = 1'b1;
              e_res   = fail_res(shp_pkg::ST_RANGE);
            end
          endcase
        end
      end

      S_CHECK: begin
        unique case (op)
          shp_pkg::MD_ALLOC: begin
            if (ram_rdata == '0) begin
              ram_we         = 1'b1;
              ram_wdata      = next_salt;
              free_hint_next = cur_inc;
              if (cursor >= high_water) begin
                high_water_next = cur_inc;
              end
              next_salt_next = advance_salt(next_salt);
              e_valid        = 1'b1;
              e_res          = ok_res({next_salt, 16'(cursor)}, cursor);
            end else if (cur_inc >= limc) begin
              e_valid = 1'b1;
              e_res   = fail_res(shp_pkg::ST_FULL);
            end else begin
              // probe the next slot, one per cycle
              ram_re      = 1'b1;
              ram_raddr   = cur_inc[IW-1:0];
              cursor_next = cur_inc;
            end
          end
          shp_pkg::MD_ALLOC_AT: begin
            e_valid = 1'b1;
            if (ram_rdata != '0) begin
              e_res = fail_res(shp_pkg::ST_OCCUPIED);
            end else begin
              ram_we    = 1'b1;
              ram_wdata = hreg[31:16];
              if (cursor >= high_water) begin
                high_water_next = cur_inc;
              end
              e_res = ok_res(hreg, cursor);
            end
          end
          shp_pkg::MD_FREE, shp_pkg::MD_LOOKUP: begin
            e_valid = 1'b1;
            if (ram_rdata == '0) begin
              e_res = fail_res(shp_pkg::ST_FREE);
            end else if (ram_rdata != hreg[31:16]) begin
              e_res = fail_res(shp_pkg::ST_STALE);
            end else begin
              if (op == shp_pkg::MD_FREE) begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (cursor < free_hint) begin
                  free_hint_next = cursor;
                end
              end
              e_res = ok_res(hreg, cursor);
            end
          end
          shp_pkg::MD_LOOKUP_SLOT: begin
            e_valid = 1'b1;
            if (ram_rdata == '0) begin
              e_res = fail_res(shp_pkg::ST_FREE);
            end else begin
              e_res = ok_res({ram_rdata, 16'(cursor)}, cursor);
            end
          end
          shp_pkg::MD_ITER_NEXT: begin
            if (ram_rdata != '0) begin
              e_valid = 1'b1;
              e_res   = ok_res({ram_rdata, 16'(cursor)}, cursor);
            end else if (walk_cursor >= high_water) begin
              e_valid = 1'b1;
              e_res   = fail_res(shp_pkg::ST_END);
            end else begin
              ram_re           = 1'b1;
              ram_raddr        = walk_cursor[IW-1:0];
              cursor_next      = walk_cursor;
              walk_cursor_next = wc_inc;
            end
          end
          default: begin
            e_valid = 1'b1;
            e_res   = fail_res(shp_pkg::ST_RANGE);
          end
        endcase
      end

      S_HOLD: begin
        if (out_free) begin
          obuf_next      = hold;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
    endcase

    // result goes straight to the output register when it has room
    if (e_valid) begin
      if (out_free) begin
        obuf_next      = e_res;
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end else begin
        hold_next  = e_res;
        state_next = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_ptr     <= '0;
      clr_boot    <= 1'b1;
      walk_cursor <= '0;
      free_hint   <= '0;
      high_water  <= '0;
      next_salt   <= shp_pkg::INIT_SALT_RST;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      clr_ptr     <= clr_ptr_next;
      clr_boot    <= clr_boot_next;
      walk_cursor <= walk_cursor_next;
      free_hint   <= free_hint_next;
      high_water  <= high_water_next;
      next_salt   <= next_salt_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    hreg   <= hreg_next;
    cursor <= cursor_next;
    obuf   <= obuf_next;
    hold   <= hold_next;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit   <= shp_pkg::SLOT_LIMIT_RST;
      initial_salt <= shp_pkg::INIT_SALT_RST;
      pool_enabled <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        shp_pkg::CFG_SLOT_LIMIT:   slot_limit   <= cfg_data[shp_pkg::LIMIT_W-1:0];
        shp_pkg::CFG_INITIAL_SALT: initial_salt <= cfg_data;
        shp_pkg::CFG_POOL_ENABLED: pool_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  a_hw_bound: assert property (@(posedge clk) disable iff (rst)
    (high_water <= CAPC) && (free_hint <= CAPC))
    else $error("high_water or free_hint beyond capacity");

  a_salt_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_salt[shp_pkg::SALT_W-1])
    else $error("next salt lost its top bit");

  a_err_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != shp_pkg::ST_OK) |->
      (handle_out == shp_pkg::NULL_HANDLE && slot_out == '0))
    else $error("refused request carries a handle");

  a_hold_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> out_valid)
    else $error("result parked while output register empty");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_CHECK))
    else $error("salt table written outside clear or check");

endmodule

// ===== src/shp_salt_ram.sv =====
// Salt table storage: one write port, one read port, registered read data.
// Depends on shp_pkg for the salt width.
module shp_salt_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [shp_pkg::SALT_W-1:0]  wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [shp_pkg::SALT_W-1:0]  rdata
);

  logic [shp_pkg::SALT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
